>>> sv/half_trapezoid_motion_profile_macros.svh
// ----------------------------------------------------------------------------
// half_trapezoid_motion_profile_macros: assertion macros
// clocked implication checks, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef HALF_TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define HALF_TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HTMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htmp assertion failed: same-cycle implication");
// next-cycle implication
`define HTMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htmp assertion failed: next-cycle implication");
`else
`define HTMP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HTMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/htmp_pkg.sv
// ----------------------------------------------------------------------------
// htmp_pkg: shared types and constants
// widths, register codes, derived state and saturating position add
// ----------------------------------------------------------------------------
`default_nettype none

package htmp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 48;
  localparam int SPD_W      = 32;
  localparam int ACC_W      = 31;
  localparam int TIME_W     = 32;
  localparam int RT_W       = TIME_W - 1;          // ramp end time, never negative
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POS_W;
  localparam int SUM_W      = SPD_W + 1;           // sum or difference of two speeds
  localparam int NUM_W      = SPD_W + FRAC_BITS;   // divider numerator
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int PROD1_W    = SPD_W + RT_W;
  localparam int PROD2_W    = SUM_W + RT_W;
  localparam int SCL_W      = PROD1_W - FRAC_BITS; // also PROD2_W - FRAC_BITS - 1
  localparam int PSUM_W     = POS_W + 1;

  localparam logic [RT_W-1:0]         RAMP_T_MAX = '1;
  localparam logic signed [POS_W-1:0] POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [SPD_W-1:0] SPD_MAX    = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_MIN    = {1'b1, {(SPD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRUISE_SPEED   = 2'd0,
    CFG_ACCEL_LIMIT    = 2'd1,
    CFG_START_POSITION = 2'd2,
    CFG_START_SPEED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DRV_IDLE,
    DRV_SETUP,
    DRV_DIV,
    DRV_SAT,
    DRV_MUL,
    DRV_ADD
  } drv_state_e;

  typedef struct packed {
    logic signed [SPD_W-1:0] cruise_speed;
    logic [ACC_W-1:0]        accel_limit;
    logic signed [POS_W-1:0] start_position;
    logic signed [SPD_W-1:0] start_speed;
  } htmp_cfg_t;

  typedef struct packed {
    logic                    ramp_dec;       // ramp acceleration is negative
    logic [RT_W-1:0]         ramp_end_time;
    logic signed [POS_W-1:0] cruise_start_pos;
  } htmp_derived_t;

  // base plus or minus a magnitude, clamped to the position range
  function automatic logic signed [POS_W-1:0] pos_add(
    input logic signed [POS_W-1:0] base,
    input logic [SCL_W-1:0]        mag,
    input logic                    neg
  );
    logic signed [PSUM_W-1:0] b_ext;
    logic signed [PSUM_W-1:0] a_ext;
    logic signed [PSUM_W-1:0] s;
    logic signed [POS_W-1:0]  r;
    b_ext = {base[POS_W-1], base};
    a_ext = {{(PSUM_W-SCL_W){1'b0}}, mag};
    if (neg) begin
      a_ext = -a_ext;
    end
    s = b_ext + a_ext;
    if (s[PSUM_W-1] != s[POS_W-1]) begin
      r = s[PSUM_W-1] ? POS_MIN : POS_MAX;
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/half_trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// half_trapezoid_motion_profile: trapezoidal velocity profile, ramp half
// register file, setup sequencer and pipelined query evaluator
// ----------------------------------------------------------------------------
// usage
// - registers are written through cfg_we_i / cfg_idx_i / cfg_data_i, one per
//   clock; user must write only with no item in flight; block does not enforce
// - each write starts a setup pass (an operand step, the one-bit-per-cycle
//   restoring divider for the ramp end time, then saturate, multiply and add
//   for the cruise start position); busy is high throughout and start is
//   ignored
// - an item (query_time_i) is taken at a clock edge with start high and busy
//   low; with busy low a new item can be taken every cycle
// - each item gives one result after the seven register stages, shown for one
//   cycle with done_o high
// - the receiver cannot stall, the pipeline never holds
// - reset clears all registers and derived values to zero and drops all
//   items in flight; busy is low after reset
// ----------------------------------------------------------------------------
`default_nettype none

module half_trapezoid_motion_profile
  import htmp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [TIME_W-1:0] query_time_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic                     done_o,
  output logic                     valid_res_o,
  output logic signed [SPD_W-1:0]  speed_out_o,
  output logic signed [POS_W-1:0]  position_out_o,
  output logic signed [SPD_W-1:0]  accel_out_o,
  output logic                     cruising_o
);

  htmp_cfg_t     cfg_q, cfg_d;
  htmp_derived_t drv;
  logic          drv_busy;
  logic          accept;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CRUISE_SPEED:   cfg_d.cruise_speed   = cfg_data_i[SPD_W-1:0];
        CFG_ACCEL_LIMIT:    cfg_d.accel_limit    = cfg_data_i[ACC_W-1:0];
        CFG_START_POSITION: cfg_d.start_position = cfg_data_i[POS_W-1:0];
        CFG_START_SPEED:    cfg_d.start_speed    = cfg_data_i[SPD_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy   = drv_busy;
  assign accept = start && !drv_busy;

  htmp_derive u_derive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_we_i),
    .cfg_i    (cfg_q),
    .busy_o   (drv_busy),
    .drv_o    (drv)
  );

  htmp_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .query_time_i   (query_time_i),
    .cfg_i          (cfg_q),
    .drv_i          (drv),
    .done_o         (done_o),
    .valid_res_o    (valid_res_o),
    .speed_out_o    (speed_out_o),
    .position_out_o (position_out_o),
    .accel_out_o    (accel_out_o),
    .cruising_o     (cruising_o)
  );

endmodule

`default_nettype wire

>>> sv/htmp_derive.sv
// ----------------------------------------------------------------------------
// htmp_derive: profile setup sequencer
// ramp sign, ramp end time by restoring division, cruise start position
// ----------------------------------------------------------------------------
`default_nettype none
`include "half_trapezoid_motion_profile_macros.svh"

module htmp_derive
  import htmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_i,
  input  htmp_cfg_t     cfg_i,
  output logic          busy_o,
  output htmp_derived_t drv_o
);

  drv_state_e state_q, state_d;

  logic [DIV_CNT_W-1:0]    cnt_q;
  logic [NUM_W-1:0]        quo_q;      // numerator shifts out, quotient shifts in
  logic [ACC_W-1:0]        rem_q;
  logic                    diff_zero_q;
  logic [SUM_W-1:0]        sum_mag_q;
  logic                    sum_neg_q;
  logic [PROD2_W-1:0]      prod_q;
  logic                    ramp_dec_q;
  logic [RT_W-1:0]         ramp_end_q;
  logic signed [POS_W-1:0] csp_q;

  logic signed [SUM_W-1:0] diff;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        diff_mag;
  logic [SUM_W-1:0]        sum_mag;
  logic [ACC_W:0]          rem_sh;
  logic [ACC_W:0]          rem_sub;
  logic                    rem_ge;
  logic [RT_W-1:0]         quo_sat;

  always_comb begin
    diff     = {cfg_i.cruise_speed[SPD_W-1], cfg_i.cruise_speed}
             - {cfg_i.start_speed[SPD_W-1], cfg_i.start_speed};
    sum      = {cfg_i.cruise_speed[SPD_W-1], cfg_i.cruise_speed}
             + {cfg_i.start_speed[SPD_W-1], cfg_i.start_speed};
    diff_mag = diff[SUM_W-1] ? (~diff + 1'b1) : diff;
    sum_mag  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    rem_sh   = {rem_q, quo_q[NUM_W-1]};
    rem_ge   = (rem_sh >= {1'b0, cfg_i.accel_limit});
    rem_sub  = rem_sh - {1'b0, cfg_i.accel_limit};
    quo_sat  = (quo_q[NUM_W-1:RT_W] != '0) ? RAMP_T_MAX : quo_q[RT_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DRV_IDLE:  state_d = DRV_IDLE;
      DRV_SETUP: state_d = DRV_DIV;
      DRV_DIV:   if (cnt_q == '0) state_d = DRV_SAT;
      DRV_SAT:   state_d = DRV_MUL;
      DRV_MUL:   state_d = DRV_ADD;
      DRV_ADD:   state_d = DRV_IDLE;
      default:   state_d = DRV_IDLE;
    endcase
    // any register write restarts the setup
    if (cfg_wr_i) begin
      state_d = DRV_SETUP;
    end
  end

  // outputs
  always_comb begin
    busy_o                 = (state_q != DRV_IDLE);
    drv_o.ramp_dec         = ramp_dec_q;
    drv_o.ramp_end_time    = ramp_end_q;
    drv_o.cruise_start_pos = csp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= DRV_IDLE;
      ramp_dec_q <= 1'b0;
      ramp_end_q <= '0;
      csp_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        DRV_SETUP: ramp_dec_q <= diff[SUM_W-1];
        DRV_SAT: begin
          if (diff_zero_q) begin
            ramp_end_q <= '0;
          end else if (cfg_i.accel_limit == '0) begin
            ramp_end_q <= RAMP_T_MAX;
          end else begin
            ramp_end_q <= quo_sat;
          end
        end
        DRV_ADD: csp_q <= pos_add(cfg_i.start_position,
                                  prod_q[PROD2_W-1:FRAC_BITS+1], sum_neg_q);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DRV_SETUP: begin
        quo_q       <= {diff_mag[SPD_W-1:0], {FRAC_BITS{1'b0}}};
        rem_q       <= '0;
        cnt_q       <= DIV_CNT_W'(NUM_W - 1);
        diff_zero_q <= (diff == '0);
        sum_mag_q   <= sum_mag;
        sum_neg_q   <= sum[SUM_W-1];
      end
      DRV_DIV: begin
        quo_q <= {quo_q[NUM_W-2:0], rem_ge};
        rem_q <= rem_ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
      DRV_MUL: prod_q <= PROD2_W'(sum_mag_q) * PROD2_W'(ramp_end_q);
      default: begin
      end
    endcase
  end

  `HTMP_ASSERT_NEXT(a_wr_restarts, clk_i, rst_ni, cfg_wr_i, state_q == DRV_SETUP)
  `HTMP_ASSERT_IMPL(a_no_limit_sat, clk_i, rst_ni, state_q == DRV_MUL && cfg_i.accel_limit == '0 && !diff_zero_q, ramp_end_q == RAMP_T_MAX)

endmodule

`default_nettype wire

>>> sv/htmp_eval.sv
// ----------------------------------------------------------------------------
// htmp_eval: query evaluator pipeline
// seven register stages from query time to speed, position and acceleration
// ----------------------------------------------------------------------------
`default_nettype none
`include "half_trapezoid_motion_profile_macros.svh"

module htmp_eval
  import htmp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic signed [TIME_W-1:0] query_time_i,
  input  htmp_cfg_t               cfg_i,
  input  htmp_derived_t           drv_i,
  output logic                    done_o,
  output logic                    valid_res_o,
  output logic signed [SPD_W-1:0] speed_out_o,
  output logic signed [POS_W-1:0] position_out_o,
  output logic signed [SPD_W-1:0] accel_out_o,
  output logic                    cruising_o
);

  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [SCL_W+1:0] s);
    logic [SCL_W-SPD_W+2:0]  hi;
    logic signed [SPD_W-1:0] r;
    hi = s[SCL_W+1:SPD_W-1];
    if (hi == '0 || hi == '1) begin
      r = s[SPD_W-1:0];
    end else begin
      r = s[SCL_W+1] ? SPD_MIN : SPD_MAX;
    end
    return r;
  endfunction

  // stage 1: captured query
  logic                     v1_q;
  logic signed [TIME_W-1:0] t1_q;
  // stage 2: segment decode, first product operands
  logic                     v2_q, neg2_q, ramp2_q, sgn2_q;
  logic [RT_W-1:0]          t2_q, b2_q;
  logic [SPD_W-1:0]         a2_q;
  // stage 3: first product
  logic                     v3_q, neg3_q, ramp3_q, sgn3_q;
  logic [RT_W-1:0]          t3_q;
  logic [PROD1_W-1:0]       p3_q;
  // stage 4: speed
  logic                     v4_q, neg4_q, ramp4_q, sgn4_q;
  logic [RT_W-1:0]          t4_q;
  logic signed [SPD_W-1:0]  spd4_q;
  logic [SCL_W-1:0]         scl4_q;
  // stage 5: second product operand
  logic                     v5_q, neg5_q, ramp5_q, sgn5_q;
  logic [RT_W-1:0]          t5_q;
  logic signed [SPD_W-1:0]  spd5_q;
  logic [SCL_W-1:0]         scl5_q;
  logic [SUM_W-1:0]         smag5_q;
  // stage 6: second product
  logic                     v6_q, neg6_q, ramp6_q, sgn6_q;
  logic signed [SPD_W-1:0]  spd6_q;
  logic [SCL_W-1:0]         scl6_q;
  logic [PROD2_W-1:0]       p6_q;
  // output registers
  logic                     done_q, valid_res_q, cruising_q;
  logic signed [SPD_W-1:0]  speed_q, accel_q;
  logic signed [POS_W-1:0]  pos_q;

  logic [RT_W-1:0]          tm2, dt2;
  logic                     ramp2;
  logic [SPD_W-1:0]         vmag2;
  logic [SCL_W-1:0]         scl4;
  logic signed [SCL_W+1:0]  dv4, spd_sum4;
  logic signed [SUM_W-1:0]  sum5;
  logic [SUM_W-1:0]         smag5;
  logic [SPD_W-1:0]         acc_mag, racc;
  logic [SCL_W-1:0]         pmag;
  logic signed [POS_W-1:0]  pbase;

  always_comb begin
    tm2   = t1_q[RT_W-1:0];
    ramp2 = (tm2 <= drv_i.ramp_end_time);
    dt2   = tm2 - drv_i.ramp_end_time;
    vmag2 = cfg_i.cruise_speed[SPD_W-1] ? (~cfg_i.cruise_speed + 1'b1) : cfg_i.cruise_speed;

    scl4     = p3_q[PROD1_W-1:FRAC_BITS];
    dv4      = {2'b00, scl4};
    if (sgn3_q) begin
      dv4 = -dv4;
    end
    spd_sum4 = {{(SCL_W+2-SPD_W){cfg_i.start_speed[SPD_W-1]}}, cfg_i.start_speed} + dv4;

    sum5  = {spd4_q[SPD_W-1], spd4_q} + {cfg_i.start_speed[SPD_W-1], cfg_i.start_speed};
    smag5 = sum5[SUM_W-1] ? (~sum5 + 1'b1) : sum5;

    acc_mag = {1'b0, cfg_i.accel_limit};
    racc    = drv_i.ramp_dec ? (~acc_mag + 1'b1) : acc_mag;
    // ramp position halves the speed sum, cruise position adds from cruise start
    pmag    = ramp6_q ? p6_q[PROD2_W-1:FRAC_BITS+1] : scl6_q;
    pbase   = ramp6_q ? cfg_i.start_position : drv_i.cruise_start_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      done_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= query_time_i;

    neg2_q  <= t1_q[TIME_W-1];
    ramp2_q <= ramp2;
    t2_q    <= tm2;
    a2_q    <= ramp2 ? acc_mag : vmag2;
    b2_q    <= ramp2 ? tm2 : dt2;
    sgn2_q  <= ramp2 ? drv_i.ramp_dec : cfg_i.cruise_speed[SPD_W-1];

    neg3_q  <= neg2_q;
    ramp3_q <= ramp2_q;
    t3_q    <= t2_q;
    sgn3_q  <= sgn2_q;
    p3_q    <= PROD1_W'(a2_q) * PROD1_W'(b2_q);

    neg4_q  <= neg3_q;
    ramp4_q <= ramp3_q;
    t4_q    <= t3_q;
    sgn4_q  <= sgn3_q;
    spd4_q  <= ramp3_q ? sat_spd(spd_sum4) : cfg_i.cruise_speed;
    scl4_q  <= scl4;

    neg5_q  <= neg4_q;
    ramp5_q <= ramp4_q;
    t5_q    <= t4_q;
    sgn5_q  <= ramp4_q ? sum5[SUM_W-1] : sgn4_q;
    spd5_q  <= spd4_q;
    scl5_q  <= scl4_q;
    smag5_q <= smag5;

    neg6_q  <= neg5_q;
    ramp6_q <= ramp5_q;
    sgn6_q  <= sgn5_q;
    spd6_q  <= spd5_q;
    scl6_q  <= scl5_q;
    p6_q    <= PROD2_W'(smag5_q) * PROD2_W'(t5_q);

    // negative time gives an all-zero item
    if (neg6_q) begin
      valid_res_q <= 1'b0;
      speed_q     <= '0;
      pos_q       <= '0;
      accel_q     <= '0;
      cruising_q  <= 1'b0;
    end else begin
      valid_res_q <= 1'b1;
      speed_q     <= spd6_q;
      pos_q       <= pos_add(pbase, pmag, sgn6_q);
      accel_q     <= ramp6_q ? racc : '0;
      cruising_q  <= !ramp6_q;
    end
  end

  assign done_o         = done_q;
  assign valid_res_o    = valid_res_q;
  assign speed_out_o    = speed_q;
  assign position_out_o = pos_q;
  assign accel_out_o    = accel_q;
  assign cruising_o     = cruising_q;

  `HTMP_ASSERT_NEXT(a_out_latency, clk_i, rst_ni, v6_q, done_q)
  `HTMP_ASSERT_IMPL(a_neg_zero, clk_i, rst_ni, done_q && !valid_res_q, speed_q == '0 && pos_q == '0 && accel_q == '0 && !cruising_q)
  `HTMP_ASSERT_IMPL(a_cruise_hold, clk_i, rst_ni, done_q && cruising_q, accel_q == '0 && speed_q == cfg_i.cruise_speed)

endmodule

`default_nettype wire

>>> sim/half_trapezoid_motion_profile_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_trapezoid_motion_profile_checker: result predictor and scoreboard
// mirrors the register writes, derives the ramp state the same way, predicts
// one sample per accepted item and compares each result in order
// ----------------------------------------------------------------------------

module half_trapezoid_motion_profile_checker
  import htmp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic signed [TIME_W-1:0] query_time_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     done_i,
  input  logic                     valid_res_i,
  input  logic signed [SPD_W-1:0]  speed_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [SPD_W-1:0]  accel_i,
  input  logic                     cruising_i,
  output int                       pending_o,
  output logic [RT_W-1:0]          ramp_end_o,
  output int                       errors_o
);

  typedef struct packed {
    logic                    valid;
    logic signed [SPD_W-1:0] speed;
    logic signed [POS_W-1:0] position;
    logic signed [SPD_W-1:0] accel;
    logic                    cruising;
  } motion_sample_t;

  // register copies and derived ramp state
  longint cruise_v, limit_a, start_p, start_v;
  longint ramp_a, ramp_t, cruise_p;

  motion_sample_t pending_samples[$];
  motion_sample_t want;
  int             fail_count;

  function automatic longint unsigned mag64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // (x * y) >> sh, truncated toward zero
  function automatic longint scale_trunc(longint x, longint y, int sh);
    longint unsigned m;
    m = (mag64(x) * mag64(y)) >> sh;
    return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_position(longint a, longint b);
    longint s;
    s = a + b;
    if (s > POS_MAX) s = POS_MAX;
    if (s < POS_MIN) s = POS_MIN;
    return s;
  endfunction

  function automatic void derive_ramp();
    longint          diff;
    longint unsigned q;
    diff   = cruise_v - start_v;
    ramp_a = (start_v > cruise_v) ? -limit_a : limit_a;
    if (diff == 0) begin
      q = 0;
    end else if (limit_a == 0) begin
      // no acceleration toward a different speed: ramp never ends
      q = RAMP_T_MAX;
    end else begin
      q = (mag64(diff) << FRAC_BITS) / limit_a;
      if (q > RAMP_T_MAX) q = RAMP_T_MAX;
    end
    ramp_t   = q;
    cruise_p = clamp_position(start_p,
                              scale_trunc(cruise_v + start_v, ramp_t, FRAC_BITS + 1));
  endfunction

  function automatic motion_sample_t eval_profile(logic signed [TIME_W-1:0] t);
    motion_sample_t r;
    longint         tl, spd, pos;
    r  = '0;
    tl = t;
    if (tl < 0) return r;
    r.valid = 1'b1;
    if (tl <= ramp_t) begin
      spd = start_v + scale_trunc(ramp_a, tl, FRAC_BITS);
      if (spd > SPD_MAX) spd = SPD_MAX;
      if (spd < SPD_MIN) spd = SPD_MIN;
      pos = clamp_position(start_p, scale_trunc(spd + start_v, tl, FRAC_BITS + 1));
      r.accel    = ramp_a[SPD_W-1:0];
      r.cruising = 1'b0;
    end else begin
      spd = cruise_v;
      pos = clamp_position(cruise_p, scale_trunc(cruise_v, tl - ramp_t, FRAC_BITS));
      r.accel    = '0;
      r.cruising = 1'b1;
    end
    r.speed    = spd[SPD_W-1:0];
    r.position = pos[POS_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string what, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_v = 0;
      limit_a  = 0;
      start_p  = 0;
      start_v  = 0;
      derive_ramp();
      pending_samples.delete();
      pending_o  <= 0;
      ramp_end_o <= '0;
      errors_o   <= fail_count;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CRUISE_SPEED:   cruise_v = $signed(cfg_data_i[SPD_W-1:0]);
          CFG_ACCEL_LIMIT:    limit_a  = cfg_data_i[ACC_W-1:0];
          CFG_START_POSITION: start_p  = $signed(cfg_data_i[POS_W-1:0]);
          CFG_START_SPEED:    start_v  = $signed(cfg_data_i[SPD_W-1:0]);
          default: ;
        endcase
        derive_ramp();
      end
      if (start_i && !busy_i) begin
        pending_samples.push_back(eval_profile(query_time_i));
      end
      if (done_i) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: result with no item waiting, expected none actual %h", $time,
                   {valid_res_i, speed_i, position_i, accel_i, cruising_i});
          fail_count++;
        end else begin
          want = pending_samples.pop_front();
          compare_field("valid_res", want.valid, valid_res_i);
          compare_field("speed", want.speed, speed_i);
          compare_field("position", want.position, position_i);
          compare_field("accel", want.accel, accel_i);
          compare_field("cruising", want.cruising, cruising_i);
        end
      end
      pending_o  <= pending_samples.size();
      ramp_end_o <= ramp_t[RT_W-1:0];
      errors_o   <= fail_count;
    end
  end

endmodule

>>> sim/half_trapezoid_motion_profile_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_trapezoid_motion_profile_tb: testbench top
// directed corner cases, then random register settings each followed by a
// run of random query times sent in bursts; the checker predicts and compares
// ----------------------------------------------------------------------------

module half_trapezoid_motion_profile_tb;
  import htmp_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int NUM_PHASES = 21;
  localparam logic signed [TIME_W-1:0] T_MAX = 32'sh7fff_ffff;
  localparam logic signed [TIME_W-1:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0] ONE_S = 32'sh0001_0000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [TIME_W-1:0] query_time;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     done;
  logic                     valid_res;
  logic signed [SPD_W-1:0]  speed;
  logic signed [POS_W-1:0]  position;
  logic signed [SPD_W-1:0]  accel;
  logic                     cruising;

  int              pending;
  int              errors;
  logic [RT_W-1:0] ramp_end;
  int              idle_cycles;
  int              burst_left;

  half_trapezoid_motion_profile DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .query_time_i   (query_time),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_o         (done),
    .valid_res_o    (valid_res),
    .speed_out_o    (speed),
    .position_out_o (position),
    .accel_out_o    (accel),
    .cruising_o     (cruising)
  );

  half_trapezoid_motion_profile_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .query_time_i (query_time),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .done_i       (done),
    .valid_res_i  (valid_res),
    .speed_i      (speed),
    .position_i   (position),
    .accel_i      (accel),
    .cruising_i   (cruising),
    .pending_o    (pending),
    .ramp_end_o   (ramp_end),
    .errors_o     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // no item, result or write for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one register write, then wait out the setup pass
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};   // unused upper bits get junk
    case (idx)
      CFG_ACCEL_LIMIT:    word[ACC_W-1:0] = value[ACC_W-1:0];
      CFG_START_POSITION: word = value;
      default:            word[SPD_W-1:0] = value[SPD_W-1:0];
    endcase
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    while (!busy) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // send one item; keep start high when the burst goes on
  task automatic push_time(logic signed [TIME_W-1:0] t, bit hold_on);
    start      <= 1'b1;
    query_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!hold_on) begin
      start <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 30) : $urandom_range(12);
    end
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(cfg_idx_e idx);
    logic [CFG_DATA_W-1:0] v;
    int                    sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(9);
    case (idx)
      CFG_ACCEL_LIMIT: begin
        case (sel)
          0:             v = '0;
          1:             v = {1'b0, {ACC_W{1'b1}}};
          2, 3, 4, 5, 6: v = $urandom_range(50 << FRAC_BITS, 1 << (FRAC_BITS - 4));
          7:             v = $urandom_range(255, 1);
          default:       v[CFG_DATA_W-1:ACC_W] = '0;
        endcase
      end
      CFG_START_POSITION: begin
        case (sel)
          0:             v = POS_MAX;
          1:             v = POS_MIN;
          2, 3, 4, 5, 6: v = longint'($urandom_range(2000 << FRAC_BITS)) -
                             longint'(1000 << FRAC_BITS);
          default: ;
        endcase
      end
      default: begin
        // speeds: few distinct small values make equal speeds common
        case (sel)
          0:             v = SPD_MAX;
          1:             v = SPD_MIN;
          2:             v = '0;
          3, 4, 5, 6:    v = longint'($urandom_range(400 << FRAC_BITS)) -
                             longint'(200 << FRAC_BITS);
          7:             v = longint'($urandom_range(3)) << FRAC_BITS;
          default: ;
        endcase
      end
    endcase
    return v;
  endfunction

  // query times clustered on the ramp, around its end and in cruise
  function automatic logic signed [TIME_W-1:0] pick_time();
    longint tr, t;
    tr = ramp_end;
    case ($urandom_range(19))
      0, 1:              t = -longint'($urandom_range(T_MAX, 1));
      2, 3, 4:           t = tr + $urandom_range(4) - 2;
      5, 6, 7, 8, 9, 10: t = $urandom_range(ramp_end, 0);
      11, 12, 13, 14:    t = tr + $urandom_range(1 << 20, 1);
      15, 16:            t = $signed($urandom);
      17:                t = 0;
      18:                t = T_MAX;
      default:           t = $urandom_range(1) ? T_MIN : -1;
    endcase
    if (t > T_MAX) t = T_MAX;
    return t[TIME_W-1:0];
  endfunction

  initial begin
    int n_items;
    int rot;
    int idx;
    bit [3:0] mask;

    rst_n      = 1'b0;
    start      = 1'b0;
    query_time = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: all zero, ramp ends at once
    push_time(0, 1);
    push_time(1, 1);
    push_time(-1, 1);
    push_time(T_MAX, 1);
    push_time(T_MIN, 0);
    drain_results();

    // plain acceleration ramp, ends at 5 s
    write_reg(CFG_CRUISE_SPEED, 10 << FRAC_BITS);
    write_reg(CFG_ACCEL_LIMIT, 2 << FRAC_BITS);
    write_reg(CFG_START_POSITION, 100 << FRAC_BITS);
    write_reg(CFG_START_SPEED, 0);
    push_time(0, 1);
    push_time(5 * ONE_S, 1);
    push_time(5 * ONE_S + 1, 1);
    push_time(ONE_S * 5 / 2, 1);
    push_time(T_MAX, 1);
    push_time(-ONE_S, 0);
    drain_results();

    // zero limit with unequal speeds: ramp never ends
    write_reg(CFG_ACCEL_LIMIT, 0);
    push_time(T_MAX, 1);
    push_time(ONE_S, 0);
    drain_results();

    // equal speeds with zero limit
    write_reg(CFG_START_SPEED, 10 << FRAC_BITS);
    push_time(0, 1);
    push_time(1, 1);
    push_time(3 * ONE_S, 0);
    drain_results();

    // full-scale deceleration from the top of the range
    write_reg(CFG_CRUISE_SPEED, SPD_MIN);
    write_reg(CFG_START_SPEED, SPD_MAX);
    write_reg(CFG_ACCEL_LIMIT, {1'b0, {ACC_W{1'b1}}});
    write_reg(CFG_START_POSITION, POS_MAX);
    push_time(0, 1);
    push_time(2 * ONE_S, 1);
    push_time(T_MAX, 0);
    drain_results();

    // position clamps at both ends
    write_reg(CFG_CRUISE_SPEED, SPD_MAX);
    write_reg(CFG_START_SPEED, SPD_MAX);
    push_time(T_MAX, 1);
    push_time(0, 0);
    drain_results();
    write_reg(CFG_CRUISE_SPEED, SPD_MIN);
    write_reg(CFG_START_SPEED, SPD_MIN);
    write_reg(CFG_START_POSITION, POS_MIN);
    push_time(T_MAX, 0);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mask = $urandom_range(15, 1);
      rot  = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
        idx = (k + rot) % 4;
        if (mask[idx]) write_reg(cfg_idx_e'(idx), pick_setting(cfg_idx_e'(idx)));
      end
      n_items = $urandom_range(120, 40);
      for (int i = 0; i < n_items; i++) begin
        push_time(pick_time(), i != n_items - 1);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
